// ----- rtl/u2mr_pkg.sv -----
// shared types, constants and the mac roman lookup for the utf-8 transcoder
package u2mr_pkg;

  localparam logic [7:0] QMARK = 8'h3F;
  localparam int unsigned CpW = 21;

  // pending results of one input word: question marks first, then an optional tail byte
  typedef struct packed {
    logic [1:0] qcnt;
    logic       tail_vld;
    logic [7:0] tail;
  } burst_t;

  // decoder sequence state, exported for checks
  typedef struct packed {
    logic [1:0] bse;
    logic [1:0] ctk;
  } dec_st_t;

  localparam logic [15:0] ROMAN_HI [128] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  // code point to mac roman byte, question mark on a miss
  function automatic logic [7:0] map_cp(input logic [CpW-1:0] cp);
    logic [7:0] res;
    res = QMARK;
    if (cp < CpW'(8'h80)) begin
      res = cp[7:0];
    end else begin
      for (int k = 0; k < 128; k++) begin
        if (cp == {5'd0, ROMAN_HI[k]}) begin
          res = {1'b1, 7'(k)};
        end
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/u2mr_decode.sv -----
// utf-8 sequence decoder: holds the open sequence and turns one byte into a result burst
module u2mr_decode import u2mr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  output burst_t     burst_o,
  output logic       empty_o,
  output dec_st_t    st_o
);

  logic [1:0]     bse_q, bse_d;
  logic [1:0]     ctk_q, ctk_d;
  logic [CpW-1:0] acc_q, acc_d;
  logic [1:0]     flush_n;
  logic [CpW-1:0] acc_sh;
  burst_t         burst;

  always_comb begin
    flush_n = (bse_q != 2'd0) ? 2'(ctk_q + 2'd1) : 2'd0;
    acc_sh  = {acc_q[CpW-7:0], byte_i[5:0]};
    burst   = '{qcnt: 2'd0, tail_vld: 1'b0, tail: QMARK};
    bse_d   = bse_q;
    ctk_d   = ctk_q;
    acc_d   = acc_q;
    if (eot_i || byte_i == 8'h00) begin
      burst.qcnt = flush_n;
      bse_d = 2'd0;
      ctk_d = 2'd0;
      acc_d = '0;
    end else if (bse_q != 2'd0 && byte_i[7:6] == 2'b10) begin
      bse_d = bse_q - 2'd1;
      ctk_d = ctk_q + 2'd1;
      acc_d = acc_sh;
      if (bse_q == 2'd1) begin
        burst.tail_vld = 1'b1;
        burst.tail     = map_cp(acc_sh);
        ctk_d = 2'd0;
        acc_d = '0;
      end
    end else begin
      // broken sequence flushes first, then the byte is a fresh lead
      burst.qcnt = flush_n;
      bse_d = 2'd0;
      ctk_d = 2'd0;
      acc_d = '0;
      if (byte_i[7] == 1'b0) begin
        burst.tail_vld = 1'b1;
        burst.tail     = byte_i;
      end else if (byte_i[7:5] == 3'b110) begin
        acc_d = CpW'(byte_i[4:0]);
        bse_d = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        acc_d = CpW'(byte_i[3:0]);
        bse_d = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        acc_d = CpW'(byte_i[2:0]);
        bse_d = 2'd3;
      end else begin
        burst.tail_vld = 1'b1;
        burst.tail     = QMARK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bse_q <= 2'd0;
      ctk_q <= 2'd0;
      acc_q <= '0;
    end else if (take_i) begin
      bse_q <= bse_d;
      ctk_q <= ctk_d;
      acc_q <= acc_d;
    end
  end

  assign burst_o = burst;
  assign empty_o = (burst.qcnt == 2'd0) && !burst.tail_vld;
  assign st_o    = '{bse: bse_q, ctk: ctk_q};

endmodule

// ----- rtl/u2mr_emit.sv -----
// result register: holds one burst and hands out one word per ready cycle
module u2mr_emit import u2mr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  logic [1:0] qleft_q;
  logic       tail_vld_q;
  logic [7:0] tail_q;
  logic       acc;

  assign out_valid_o = (qleft_q != 2'd0) || tail_vld_q;
  assign out_byte_o  = (qleft_q != 2'd0) ? QMARK : tail_q;
  assign run_last_o  = (qleft_q == 2'd1 && !tail_vld_q) || (qleft_q == 2'd0 && tail_vld_q);
  assign acc         = out_valid_o && out_ready_i;
  // slot can take a new burst when empty or when its last word leaves now
  assign free_o      = !out_valid_o || (acc && run_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qleft_q    <= 2'd0;
      tail_vld_q <= 1'b0;
    end else if (load_i) begin
      qleft_q    <= burst_i.qcnt;
      tail_vld_q <= burst_i.tail_vld;
    end else if (acc) begin
      if (qleft_q != 2'd0) begin
        qleft_q <= qleft_q - 2'd1;
      end else begin
        tail_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tail_q <= burst_i.tail;
    end
  end

endmodule

// ----- rtl/utf8_to_mac_roman_transcoder_core.sv -----
// top level of the utf-8 to mac roman transcoder
// Usage:
//   input channel (in_valid_i / in_ready_o) carries one utf-8 byte per word,
//   with end_of_text_i marking the end of a text; a zero byte acts the same.
//   output channel (out_valid_o / out_ready_i) carries mac roman bytes; each
//   input word gives zero to four output words, run_last_o marks its last.
// Data path: a word accepted from the input channel lands in the input
//   register, is decoded and loaded into the result register, and its
//   first output word is offered from there.
// Throughput: one input word per cycle while each word gives at most one
//   result and out_ready_i is high; a longer burst holds the result register
//   until its last word leaves, and the input register takes one more word
//   behind it; the decode is one 128-entry mac roman lookup per cycle.
// Reset: clears the open sequence, the input register and the result
//   register; no output is offered until input arrives.
// Stall: when out_ready_i is low the current output word is held, the
//   decoder stops at the first word that gives a result, and in_ready_o
//   drops once that word waits in the input register.
module utf8_to_mac_roman_transcoder_core import u2mr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       dec_take;
  logic       dec_empty;
  logic       emit_free;
  burst_t     dec_burst;
  dec_st_t    dec_st;

  assign dec_take   = in_vld_q && (dec_empty || emit_free);
  assign in_ready_o = !in_vld_q || dec_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  u2mr_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (dec_take),
    .byte_i  (in_byte_q),
    .eot_i   (in_eot_q),
    .burst_o (dec_burst),
    .empty_o (dec_empty),
    .st_o    (dec_st)
  );

  u2mr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (dec_take && !dec_empty),
    .burst_i     (dec_burst),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

  // every word ahead of the last one of a burst is a question mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> out_byte_o == QMARK)
    else $error("non-final word is not a question mark");

  // no sequence open means no continuations counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_st.bse == 2'd0 |-> dec_st.ctk == 2'd0)
    else $error("continuation count left over with no open sequence");

  // an open sequence never spans more than three continuations
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_st.bse != 2'd0 |-> ({1'b0, dec_st.bse} + {1'b0, dec_st.ctk}) <= 3'd3)
    else $error("open sequence longer than four bytes");

  // a waiting input word is held until the decoder takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !dec_take |=> in_vld_q && $stable(in_byte_q) && $stable(in_eot_q))
    else $error("input register lost a word");

endmodule
